// ----- src/kmm_pkg.sv -----
package kmm_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned COUNT_W  = 31;
  localparam int unsigned STREAM_W = 4;

  // Input item kind codes
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_END    = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [STREAM_W-1:0] source_stream;
    logic [KEY_W-1:0]    record_key;
    logic [COUNT_W-1:0]  record_count;
  } kmm_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]    out_key;
    logic [COUNT_W-1:0]  out_count;
    logic [STREAM_W-1:0] out_stream;
  } kmm_out_t;

  // Running minimum token that walks down the cell chain
  typedef struct packed {
    logic                live;
    logic                ready;
    logic                found;
    logic [KEY_W-1:0]    key;
    logic [COUNT_W-1:0]  count;
    logic [STREAM_W-1:0] stream;
  } kmm_sweep_t;

  // Head update and clear commands broadcast to every cell
  typedef struct packed {
    logic                upd;
    kmm_in_t             item;
    logic                clr;
    logic [STREAM_W-1:0] clr_stream;
  } kmm_cmd_t;

endpackage

// ----- src/kmm_cell.sv -----
module kmm_cell import kmm_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  kmm_cmd_t   cmd_i,
  input  kmm_sweep_t sweep_i,
  output kmm_sweep_t sweep_o
);

  localparam logic                ADDRESSABLE = (IDX < (1 << STREAM_W));
  localparam logic [STREAM_W-1:0] MY_STREAM   = STREAM_W'(IDX);

  logic               valid_q, valid_d;
  logic               ended_q, ended_d;
  logic [KEY_W-1:0]   key_q;
  logic [COUNT_W-1:0] count_q;
  logic               upd_hit;
  logic               clr_hit;
  logic               take;
  kmm_sweep_t         sweep_q, sweep_d;

  assign upd_hit = ADDRESSABLE && cmd_i.upd && (cmd_i.item.source_stream == MY_STREAM);
  assign clr_hit = ADDRESSABLE && cmd_i.clr && (cmd_i.clr_stream == MY_STREAM);

  // Apply end marks, head refills and the clear of an emitted head
  always_comb begin
    valid_d = valid_q;
    ended_d = ended_q;
    if (upd_hit) begin
      if (cmd_i.item.kind == KIND_END) begin
        ended_d = 1'b1;
      end else if (!ended_q) begin
        valid_d = 1'b1;
      end
    end
    if (clr_hit) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ended_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ended_q <= ended_d;
    end
  end

  // Head payload; only read while valid
  always_ff @(posedge clk_i) begin
    if (upd_hit && (cmd_i.item.kind == KIND_RECORD) && !ended_q) begin
      key_q   <= cmd_i.item.record_key;
      count_q <= cmd_i.item.record_count;
    end
  end

  // Strict less-than keeps the lower stream on equal keys
  assign take = valid_q && (!sweep_i.found || (key_q < sweep_i.key));

  always_comb begin
    sweep_d       = sweep_i;
    sweep_d.ready = sweep_i.ready && (valid_q || ended_q);
    if (take) begin
      sweep_d.found  = 1'b1;
      sweep_d.key    = key_q;
      sweep_d.count  = count_q;
      sweep_d.stream = MY_STREAM;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else begin
      sweep_q <= sweep_d;
    end
  end

  assign sweep_o = sweep_q;

endmodule

// ----- src/kway_merge_min_select_core.sv -----
// K-way merge head selector. One cell per stream holds that stream's head record
// and its ended flag. Each accepted item (a record or an end mark) updates its
// stream's cell, then a token walks down the cell chain one cell per cycle,
// carrying the running minimum key and an all-streams-ready flag; ties go to
// the lower stream. When every stream holds a head or has ended, the smallest
// head is sent out tagged with its stream and that head is dropped, so the
// feeder should next send a record or an end mark for out_stream. An item is
// registered in start_q, walks every cell of the chain and is held in pend_q;
// the next item is taken once pend_q resolves, into the output register when a
// head is emitted. Items naming a stream at or above NUM_STREAMS change nothing.
module kway_merge_min_select_core import kmm_pkg::*; #(
  parameter int unsigned NUM_STREAMS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  kmm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output kmm_out_t out_data_o
);

  kmm_sweep_t                 sweep [NUM_STREAMS];
  logic [NUM_STREAMS-1:0]     sweep_live;
  kmm_sweep_t                 head_tok;
  kmm_cmd_t                   cmd;
  logic                       accept;
  logic                       busy_q, busy_d;
  logic                       start_q;
  kmm_sweep_t                 pend_q;
  logic                       pend_v_q, pend_v_d;
  kmm_out_t                   out_q;
  logic                       out_v_q, out_v_d;
  logic                       emit;
  logic                       out_free;
  logic                       resolve;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  // Fresh token entering the chain
  always_comb begin
    head_tok       = '0;
    head_tok.live  = start_q;
    head_tok.ready = 1'b1;
  end

  // Pending selection result resolves into the output register
  assign emit     = pend_v_q && pend_q.ready && pend_q.found;
  assign out_free = !out_v_q || !out_stall_i;
  assign resolve  = pend_v_q && (!emit || out_free);

  always_comb begin
    cmd            = '0;
    cmd.upd        = accept;
    cmd.item       = in_data_i;
    cmd.clr        = resolve && emit;
    cmd.clr_stream = pend_q.stream;
  end

  for (genvar g = 0; g < NUM_STREAMS; g++) begin : g_cell
    if (g == 0) begin : g_first
      kmm_cell #(.IDX(g)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cmd_i  (cmd),
        .sweep_i(head_tok),
        .sweep_o(sweep[g])
      );
    end else begin : g_rest
      kmm_cell #(.IDX(g)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cmd_i  (cmd),
        .sweep_i(sweep[g-1]),
        .sweep_o(sweep[g])
      );
    end
    assign sweep_live[g] = sweep[g].live;
  end

  // Control next state
  always_comb begin
    busy_d   = busy_q;
    pend_v_d = pend_v_q;
    out_v_d  = out_v_q && out_stall_i;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (sweep[NUM_STREAMS-1].live) begin
      pend_v_d = 1'b1;
    end
    if (resolve) begin
      pend_v_d = 1'b0;
      busy_d   = 1'b0;
      if (emit) begin
        out_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      start_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      start_q  <= accept;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Capture the token leaving the chain; load the output on emission
  always_ff @(posedge clk_i) begin
    if (sweep[NUM_STREAMS-1].live) begin
      pend_q <= sweep[NUM_STREAMS-1];
    end
    if (resolve && emit) begin
      out_q.out_key    <= pend_q.key;
      out_q.out_count  <= pend_q.count;
      out_q.out_stream <= pend_q.stream;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // At most one token walks the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({sweep_live, start_q, pend_v_q}) <= 1)
    else $error("more than one selection in flight");

  // A token in flight implies the input side is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q || pend_v_q || (sweep_live != '0)) |-> busy_q)
    else $error("selection in flight while idle");

  // Busy always has a token somewhere
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (start_q || pend_v_q || (sweep_live != '0)))
    else $error("busy with no selection in flight");

  // An emitted head names an existing stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (32'(pend_q.stream) < NUM_STREAMS))
    else $error("emitted stream out of range");

  // An emission always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resolve && emit) |=> out_v_q)
    else $error("emitted record lost");

endmodule
